// ----- rtl/ptd_pkg.sv -----
package ptd_pkg;

  localparam int THRESH_WIDTH = 15;

  typedef logic [THRESH_WIDTH-1:0] thresh_t;

  localparam thresh_t THRESH_RESET = 15'd26;

  localparam logic [1:0] MODE_UNDECIDED = 2'd0;
  localparam logic [1:0] MODE_SEEK_PEAK = 2'd1;
  localparam logic [1:0] MODE_SEEK_TROUGH = 2'd2;

endpackage

// ----- rtl/peak_trough_detector.sv -----
// Channel  Direction  Handshake          Payload
// in_      input      valid / stall      sample, record_start
// out_     output     valid / stall      event_is_trough, event_index, event_value,
//                                        peak_total, trough_total
// cfg_     input      valid / ready      data (threshold)
//
// One sample is taken per cycle while in_stall is low; the detector state and
// any event register together, the event into the output register, or into a
// one-entry skid buffer behind it while a result there waits. The skid buffer
// lets input continue meanwhile; input stalls only while that buffer is full.
// Reset is synchronous and active low; the threshold resets to 26.
// cfg_ready is always high.
module peak_trough_detector #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int INDEX_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                          in_record_start,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_event_is_trough,
  output logic [INDEX_WIDTH-1:0]        out_event_index,
  output logic signed [SAMPLE_WIDTH-1:0] out_event_value,
  output logic [INDEX_WIDTH-1:0]        out_peak_total,
  output logic [INDEX_WIDTH-1:0]        out_trough_total,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  ptd_pkg::thresh_t              cfg_data
);
  import ptd_pkg::*;

  localparam int CW = ((SAMPLE_WIDTH > THRESH_WIDTH) ? SAMPLE_WIDTH : THRESH_WIDTH) + 2;
  localparam logic [INDEX_WIDTH-1:0] IDX_MAX = {INDEX_WIDTH{1'b1}};

  typedef struct packed {
    logic                          is_trough;
    logic [INDEX_WIDTH-1:0]        index;
    logic signed [SAMPLE_WIDTH-1:0] value;
    logic [INDEX_WIDTH-1:0]        peaks;
    logic [INDEX_WIDTH-1:0]        troughs;
  } result_t;

  thresh_t                        threshold_r;
  logic [1:0]                     mode_r, mode_nxt, mode_b;
  logic signed [SAMPLE_WIDTH-1:0] high_value_r, high_value_nxt, high_value_b;
  logic signed [SAMPLE_WIDTH-1:0] low_value_r, low_value_nxt, low_value_b;
  logic [INDEX_WIDTH-1:0]         high_index_r, high_index_nxt, high_index_b;
  logic [INDEX_WIDTH-1:0]         low_index_r, low_index_nxt, low_index_b;
  logic [INDEX_WIDTH-1:0]         count_r, count_nxt, count_b;
  logic [INDEX_WIDTH-1:0]         peaks_r, peaks_nxt, peaks_b;
  logic [INDEX_WIDTH-1:0]         troughs_r, troughs_nxt, troughs_b;

  logic signed [CW-1:0] x_ext, th_ext, hv_ext, lv_ext;
  logic                 high_le_x, high_drop, x_le_low, low_rise;
  logic                 emit;
  result_t              res;

  logic    out_valid_r, skid_valid_r;
  result_t out_r, skid_r;
  logic    in_acc, out_take;

  assign in_stall  = skid_valid_r;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;

  always_comb begin
    if (in_record_start) begin
      mode_b       = MODE_UNDECIDED;
      high_value_b = in_sample;
      low_value_b  = in_sample;
      high_index_b = '0;
      low_index_b  = '0;
      count_b      = '0;
      peaks_b      = '0;
      troughs_b    = '0;
    end else begin
      mode_b       = mode_r;
      high_value_b = high_value_r;
      low_value_b  = low_value_r;
      high_index_b = high_index_r;
      low_index_b  = low_index_r;
      count_b      = count_r;
      peaks_b      = peaks_r;
      troughs_b    = troughs_r;
    end

    x_ext  = CW'(in_sample);
    th_ext = CW'(signed'({1'b0, threshold_r}));
    hv_ext = CW'(high_value_b);
    lv_ext = CW'(low_value_b);

    high_le_x = hv_ext <= x_ext;
    high_drop = hv_ext >= x_ext + th_ext;
    x_le_low  = x_ext <= lv_ext;
    low_rise  = x_ext >= lv_ext + th_ext;

    count_nxt      = (count_b != IDX_MAX) ? count_b + 1'b1 : count_b;
    mode_nxt       = mode_b;
    high_value_nxt = high_value_b;
    low_value_nxt  = low_value_b;
    high_index_nxt = high_index_b;
    low_index_nxt  = low_index_b;
    peaks_nxt      = peaks_b;
    troughs_nxt    = troughs_b;
    emit           = 1'b0;
    res.is_trough  = 1'b0;
    res.index      = high_index_b;
    res.value      = high_value_b;

    case (mode_b)
      MODE_SEEK_PEAK: begin
        if (high_le_x) begin
          high_value_nxt = in_sample;
          high_index_nxt = count_b;
        end else if (high_drop) begin
          peaks_nxt     = (peaks_b != IDX_MAX) ? peaks_b + 1'b1 : peaks_b;
          emit          = 1'b1;
          low_value_nxt = in_sample;
          low_index_nxt = count_b;
          mode_nxt      = MODE_SEEK_TROUGH;
        end
      end
      MODE_SEEK_TROUGH: begin
        if (x_le_low) begin
          low_value_nxt = in_sample;
          low_index_nxt = count_b;
        end else if (low_rise) begin
          troughs_nxt    = (troughs_b != IDX_MAX) ? troughs_b + 1'b1 : troughs_b;
          emit           = 1'b1;
          res.is_trough  = 1'b1;
          res.index      = low_index_b;
          res.value      = low_value_b;
          high_value_nxt = in_sample;
          high_index_nxt = count_b;
          mode_nxt       = MODE_SEEK_PEAK;
        end
      end
      default: begin
        if (high_drop) begin
          mode_nxt = MODE_SEEK_TROUGH;
        end else if (low_rise) begin
          mode_nxt = MODE_SEEK_PEAK;
        end
        if (high_le_x) begin
          high_value_nxt = in_sample;
          high_index_nxt = count_b;
        end else if (x_le_low) begin
          low_value_nxt = in_sample;
          low_index_nxt = count_b;
        end
      end
    endcase

    res.peaks   = peaks_nxt;
    res.troughs = troughs_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r  <= THRESH_RESET;
      mode_r       <= MODE_UNDECIDED;
      high_value_r <= '0;
      low_value_r  <= '0;
      high_index_r <= '0;
      low_index_r  <= '0;
      count_r      <= '0;
      peaks_r      <= '0;
      troughs_r    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        threshold_r <= cfg_data;
      end
      if (in_acc) begin
        mode_r       <= mode_nxt;
        high_value_r <= high_value_nxt;
        low_value_r  <= low_value_nxt;
        high_index_r <= high_index_nxt;
        low_index_r  <= low_index_nxt;
        count_r      <= count_nxt;
        peaks_r      <= peaks_nxt;
        troughs_r    <= troughs_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (in_acc && emit) begin
      if (!out_valid_r || out_take) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_event_is_trough = out_r.is_trough;
  assign out_event_index     = out_r.index;
  assign out_event_value     = out_r.value;
  assign out_peak_total      = out_r.peaks;
  assign out_trough_total    = out_r.troughs;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid buffer holds a transaction while the output register is empty");

  a_event_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.peaks != '0 || out_r.troughs != '0))
    else $error("event transaction carries zero peak and trough totals");

  a_peak_turns_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && emit && !res.is_trough) |=> (mode_r == MODE_SEEK_TROUGH))
    else $error("mode did not turn to trough seeking after a peak");

  a_trough_turns_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && emit && res.is_trough) |=> (mode_r == MODE_SEEK_PEAK))
    else $error("mode did not turn to peak seeking after a trough");

endmodule

// ----- sim/peak_trough_detector_tb.sv -----
`timescale 1ns / 100ps

module peak_trough_detector_tb;
  import ptd_pkg::*;

  typedef struct {
    logic signed [15:0] sample;
    bit                 start;
    bit                 hold;
  } sample_item_t;

  typedef struct {
    logic               is_trough;
    logic [15:0]        index;
    logic signed [15:0] value;
    logic [15:0]        peaks;
    logic [15:0]        troughs;
  } detector_event_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_sample = '0;
  logic               in_record_start = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_event_is_trough;
  logic [15:0]        out_event_index;
  logic signed [15:0] out_event_value;
  logic [15:0]        out_peak_total;
  logic [15:0]        out_trough_total;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  thresh_t            cfg_data = '0;

  sample_item_t    sample_q[$];
  detector_event_t event_q[$];

  int  mismatch_count = 0;
  bit  no_idle = 1'b0;
  bit  in_took = 1'b0;
  int  gap_left = 0;
  int  stall_left = 0;

  thresh_t     thresh_now = THRESH_RESET;
  logic [1:0]  st_mode = MODE_UNDECIDED;
  int          hi_val = 0;
  int          lo_val = 0;
  logic [15:0] hi_idx = '0;
  logic [15:0] lo_idx = '0;
  logic [15:0] next_idx = '0;
  logic [15:0] n_peaks = '0;
  logic [15:0] n_troughs = '0;

  peak_trough_detector uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_sample(in_sample),
    .in_record_start(in_record_start),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_event_is_trough(out_event_is_trough),
    .out_event_index(out_event_index),
    .out_event_value(out_event_value),
    .out_peak_total(out_peak_total),
    .out_trough_total(out_trough_total),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic int pick_gap();
    int r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic void advance_detector(input logic signed [15:0] smp, input logic start);
    int              x;
    int              th;
    logic [15:0]     idx;
    detector_event_t ev;
    bit              fired;
    x = smp;
    th = thresh_now;
    fired = 1'b0;
    if (start) begin
      st_mode = MODE_UNDECIDED;
      hi_val = x;
      lo_val = x;
      hi_idx = '0;
      lo_idx = '0;
      next_idx = '0;
      n_peaks = '0;
      n_troughs = '0;
    end
    idx = next_idx;
    if (next_idx != 16'hFFFF) next_idx++;
    case (st_mode)
      MODE_SEEK_PEAK: begin
        if (hi_val <= x) begin
          hi_val = x;
          hi_idx = idx;
        end else if (hi_val >= x + th) begin
          if (n_peaks != 16'hFFFF) n_peaks++;
          ev.is_trough = 1'b0;
          ev.index = hi_idx;
          ev.value = hi_val[15:0];
          fired = 1'b1;
          lo_val = x;
          lo_idx = idx;
          st_mode = MODE_SEEK_TROUGH;
        end
      end
      MODE_SEEK_TROUGH: begin
        if (x <= lo_val) begin
          lo_val = x;
          lo_idx = idx;
        end else if (x >= lo_val + th) begin
          if (n_troughs != 16'hFFFF) n_troughs++;
          ev.is_trough = 1'b1;
          ev.index = lo_idx;
          ev.value = lo_val[15:0];
          fired = 1'b1;
          hi_val = x;
          hi_idx = idx;
          st_mode = MODE_SEEK_PEAK;
        end
      end
      default: begin
        if (hi_val >= x + th) begin
          st_mode = MODE_SEEK_TROUGH;
        end else if (x >= lo_val + th) begin
          st_mode = MODE_SEEK_PEAK;
        end
        if (hi_val <= x) begin
          hi_val = x;
          hi_idx = idx;
        end else if (x <= lo_val) begin
          lo_val = x;
          lo_idx = idx;
        end
      end
    endcase
    if (fired) begin
      ev.peaks = n_peaks;
      ev.troughs = n_troughs;
      event_q.push_back(ev);
    end
  endfunction

  always @(posedge clk) begin
    in_took = 1'b0;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) thresh_now = cfg_data;
      if (in_valid && !in_stall) begin
        in_took = 1'b1;
        advance_detector(in_sample, in_record_start);
      end
    end
  end

  always @(negedge clk) begin
    sample_item_t it;
    if (rst_n && (!in_valid || in_took)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (sample_q.size() != 0 && !(sample_q[0].hold && event_q.size() != 0)) begin
        it = sample_q.pop_front();
        in_valid <= 1'b1;
        in_sample <= it.sample;
        in_record_start <= it.start;
        gap_left = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n || no_idle) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    detector_event_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (event_q.size() == 0) begin
        flag_mismatch("unexpected event, index", out_event_index, 0);
      end else begin
        want = event_q.pop_front();
        if (out_event_is_trough !== want.is_trough)
          flag_mismatch("event_is_trough", out_event_is_trough, want.is_trough);
        if (out_event_index !== want.index)
          flag_mismatch("event_index", out_event_index, want.index);
        if (out_event_value !== want.value)
          flag_mismatch("event_value", out_event_value, want.value);
        if (out_peak_total !== want.peaks)
          flag_mismatch("peak_total", out_peak_total, want.peaks);
        if (out_trough_total !== want.troughs)
          flag_mismatch("trough_total", out_trough_total, want.troughs);
      end
    end
  end

  task automatic add_sample(input int value, input bit start, input bit hold = 1'b0);
    sample_item_t it;
    it.sample = value[15:0];
    it.start = start;
    it.hold = hold;
    sample_q.push_back(it);
  endtask

  task automatic wait_drained();
    while (sample_q.size() != 0 || in_valid || event_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(input thresh_t value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random walk whose steps scale with the threshold, so that swings cross the
  // hysteresis margin often, mixed with full-range noise and new records.
  task automatic queue_walk(input int count, input int th);
    sample_item_t it;
    int           cur;
    int           dir;
    int           span;
    int           k;
    cur = int'($urandom_range(0, 65535)) - 32768;
    dir = 1;
    span = 2 * th + 64;
    for (k = 0; k < count; k++) begin
      it.start = (k == 0) || ($urandom_range(0, 29) == 0);
      it.hold = ($urandom_range(0, 59) == 0);
      if ($urandom_range(0, 9) == 0) begin
        it.sample = 16'($urandom);
      end else begin
        if ($urandom_range(0, 3) == 0) dir = -dir;
        cur = cur + dir * int'($urandom_range(0, span));
        if (cur > 32767) begin
          cur = 32767;
          dir = -1;
        end else if (cur < -32768) begin
          cur = -32768;
          dir = 1;
        end
        it.sample = cur[15:0];
      end
      sample_q.push_back(it);
    end
  endtask

  initial begin
    int k;
    int th;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // With the reset threshold and no record start, the first sample is
    // compared against the zero extremes left by reset.
    add_sample(100, 1'b0);
    add_sample(50, 1'b0);
    add_sample(32767, 1'b0);
    add_sample(-32768, 1'b0);
    add_sample(-32768, 1'b0);
    add_sample(-32743, 1'b0);
    add_sample(-32742, 1'b0, 1'b1);
    add_sample(0, 1'b1);
    add_sample(-26, 1'b0);
    add_sample(-10, 1'b0);
    add_sample(0, 1'b0);
    add_sample(5, 1'b1);
    add_sample(5, 1'b0);
    add_sample(20, 1'b0);
    add_sample(31, 1'b0);
    add_sample(5, 1'b0);
    wait_drained();

    write_threshold(thresh_t'(0));
    add_sample(7, 1'b1);
    add_sample(7, 1'b0);
    add_sample(7, 1'b0);
    add_sample(8, 1'b0);
    add_sample(8, 1'b0);
    add_sample(7, 1'b0);
    queue_walk(90, 0);
    wait_drained();

    write_threshold(thresh_t'(32767));
    add_sample(-32768, 1'b1);
    add_sample(-1, 1'b0);
    add_sample(-32768, 1'b0);
    queue_walk(80, 32767);
    wait_drained();

    th = $urandom_range(1, 300);
    write_threshold(thresh_t'(th));
    queue_walk(100, th);
    wait_drained();

    th = $urandom_range(0, 32767);
    write_threshold(thresh_t'(th));
    queue_walk(100, th);
    wait_drained();

    // Back-to-back alternation followed by a walk, with no random input gaps or output stalls.
    no_idle = 1'b1;
    write_threshold(thresh_t'(100));
    add_sample(1000, 1'b1);
    for (k = 0; k < 20; k++) begin
      add_sample((k % 2 == 0) ? -1000 : 1000, 1'b0);
    end
    queue_walk(20, 100);
    wait_drained();
    no_idle = 1'b0;

    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
